@@ design/efp_pkg.sv @@
// efp_pkg: shared widths, stage counts and a helper function of the edge frame flow projection
// no dependencies; imported by every module of the block
`default_nettype none

package efp_pkg;

  localparam int DataW      = 32;             // width of every input and output field
  localparam int NumIn      = 12;             // input fields per transaction
  localparam int NumOut     = 4;              // projection fields per transaction
  localparam int MagW       = DataW + 1;      // exact endpoint sum or difference magnitude
  localparam int LenW       = 6;              // holds a bit length of 0 .. MagW
  localparam int NormBits   = 30;             // bits of the largest normalised component
  localparam int UnitBits   = 30;             // fraction bits of unit vectors, 1.0 = 2^UnitBits
  localparam int SqW        = 2 * NormBits + 2;  // sum of three squares
  localparam int RootW      = NormBits + 1;      // floor square root of the sum
  localparam int RootSteps  = SqW / 2 + 1;       // two radicand bits per stage
  localparam int RcpW       = 32;                // reciprocal 2^(2*UnitBits) / root
  localparam int RecipSteps = RcpW;              // one quotient bit per stage
  localparam int RemW       = 2 * UnitBits + 2;  // partial remainder of the reciprocal
  localparam int NormVecW   = 34;             // cross product component, signed
  localparam int ProdW      = NormVecW + DataW;  // one projection product
  localparam int SumW       = ProdW + 2;         // sum of three products

  // pipeline depths
  localparam int UvLat      = 4 + RootSteps + RecipSteps + 2;
  localparam int CrossLat   = 2;
  localparam int ProjLat    = 3;
  localparam int FlowDly    = UvLat + CrossLat;
  localparam int TotalLat   = 1 + FlowDly + ProjLat;

  typedef logic signed [DataW-1:0]    data_t;
  typedef logic signed [NormVecW-1:0] wvec_t;

  // per-vector side data that waits while the norm is worked out
  typedef struct packed {
    logic [2:0][NormBits-1:0] v;
    logic [2:0]               neg;
    logic                     zero;
  } uv_side_t;

  // number of bits needed to hold x, zero for zero
  function automatic logic [LenW-1:0] bit_len(input logic [MagW-1:0] x);
    logic [LenW-1:0] n;
    n = '0;
    for (int i = 0; i < MagW; i++) begin
      if (x[i]) begin
        n = LenW'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ design/efp_isqrt.sv @@
// efp_isqrt: pipelined floor square root, two radicand bits retired per stage
// depends on efp_pkg
`default_nettype none

module efp_isqrt import efp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [SqW-1:0]   sq_i,
  output logic      [RootW-1:0] root_o
);

  logic [63:0] x_q  [RootSteps];
  logic [63:0] r_q  [RootSteps];
  logic [63:0] x_d  [RootSteps];
  logic [63:0] r_d  [RootSteps];
  logic [63:0] x_in [RootSteps];
  logic [63:0] r_in [RootSteps];
  logic [63:0] trial[RootSteps];

  always_comb begin
    x_in[0] = 64'(sq_i);
    r_in[0] = '0;
    for (int k = 1; k < RootSteps; k++) begin
      x_in[k] = x_q[k-1];
      r_in[k] = r_q[k-1];
    end
    for (int k = 0; k < RootSteps; k++) begin
      trial[k] = r_in[k] + (64'(1) << (2 * (RootSteps - 1 - k)));
      if (x_in[k] >= trial[k]) begin
        x_d[k] = x_in[k] - trial[k];
        r_d[k] = (r_in[k] >> 1) + (64'(1) << (2 * (RootSteps - 1 - k)));
      end else begin
        x_d[k] = x_in[k];
        r_d[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  assign root_o = r_q[RootSteps-1][RootW-1:0];

endmodule

`default_nettype wire

@@ design/efp_recip.sv @@
// efp_recip: pipelined restoring division 2^(2*UnitBits) / root, one quotient bit per stage
// depends on efp_pkg
`default_nettype none

module efp_recip import efp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [RootW-1:0] root_i,
  output logic      [RcpW-1:0]  rcp_o
);

  logic [RemW-1:0]  rem_q [RecipSteps];
  logic [RcpW-1:0]  quo_q [RecipSteps];
  logic [RootW-1:0] div_q [RecipSteps];
  logic [RemW-1:0]  rem_d [RecipSteps];
  logic [RcpW-1:0]  quo_d [RecipSteps];
  logic [RootW-1:0] div_d [RecipSteps];
  logic [RemW-1:0]  rem_in[RecipSteps];
  logic [RcpW-1:0]  quo_in[RecipSteps];
  logic [RemW-1:0]  sub_c [RecipSteps];

  always_comb begin
    rem_in[0] = RemW'(1) << (2 * UnitBits);
    quo_in[0] = '0;
    div_d[0]  = root_i;
    for (int k = 1; k < RecipSteps; k++) begin
      rem_in[k] = rem_q[k-1];
      quo_in[k] = quo_q[k-1];
      div_d[k]  = div_q[k-1];
    end
    for (int k = 0; k < RecipSteps; k++) begin
      sub_c[k] = RemW'(div_d[k]) << (RecipSteps - 1 - k);
      if (rem_in[k] >= sub_c[k]) begin
        rem_d[k] = rem_in[k] - sub_c[k];
        quo_d[k] = quo_in[k] | (RcpW'(1) << (RecipSteps - 1 - k));
      end else begin
        rem_d[k] = rem_in[k];
        quo_d[k] = quo_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      div_q <= div_d;
    end
  end

  assign rcp_o = quo_q[RecipSteps-1];

endmodule

`default_nettype wire

@@ design/efp_unit_vec.sv @@
// efp_unit_vec: unit vector of a+b or a-b: combine, normalise, squares, root, reciprocal, scale
// depends on efp_pkg, efp_isqrt, efp_recip
`default_nettype none

module efp_unit_vec import efp_pkg::*; #(
  parameter bit Subtract = 1'b0
) (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire data_t a_i [3],
  input  wire data_t b_i [3],
  output data_t      u_o [3],
  output logic       zero_o
);

  localparam int SideDly = 2 + RootSteps + RecipSteps;

  // stage 1: exact sum or difference as sign and magnitude
  logic [2:0]           s1_neg_q;
  logic [MagW-1:0]      s1_mag_q [3];
  // stage 2: normalised components
  uv_side_t             s2_q;
  // stage 3 and 4: squares and their sum
  logic [2*NormBits-1:0] s3_sq_q [3];
  logic [SqW-1:0]       s4_sum_q;
  // side data delay while the root and reciprocal run
  uv_side_t             side_q [SideDly];
  // scale and sign stages
  logic [NormBits+RcpW-1:0] s5_prod_q [3];
  logic [2:0]           s5_neg_q;
  logic                 s5_zero_q;
  data_t                u_q [3];
  logic                 zero_q;

  logic [RootW-1:0]     root_c;
  logic [RcpW-1:0]      rcp_c;
  logic signed [MagW-1:0] comb_c [3];
  logic [LenW-1:0]      len_c;
  logic [NormBits+MagW-1:0] shift_c [3];
  uv_side_t             s2_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (Subtract) begin
        comb_c[i] = MagW'(a_i[i]) - MagW'(b_i[i]);
      end else begin
        comb_c[i] = MagW'(a_i[i]) + MagW'(b_i[i]);
      end
    end
    len_c = bit_len(s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2]);
    for (int i = 0; i < 3; i++) begin
      shift_c[i]  = {s1_mag_q[i], {NormBits{1'b0}}} >> len_c;
      s2_d.v[i]   = shift_c[i][NormBits-1:0];
    end
    s2_d.neg  = s1_neg_q;
    s2_d.zero = (len_c == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_q[i] <= comb_c[i][MagW-1];
        s1_mag_q[i] <= comb_c[i][MagW-1] ? MagW'(-comb_c[i]) : MagW'(comb_c[i]);
        s3_sq_q[i]  <= s2_q.v[i] * s2_q.v[i];
      end
      s2_q     <= s2_d;
      s4_sum_q <= SqW'(s3_sq_q[0]) + SqW'(s3_sq_q[1]) + SqW'(s3_sq_q[2]);
      side_q[0] <= s2_q;
      for (int k = 1; k < SideDly; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        s5_prod_q[i] <= side_q[SideDly-1].v[i] * rcp_c;
        u_q[i] <= s5_neg_q[i] ? -data_t'(s5_prod_q[i][NormBits+RcpW-1:UnitBits])
                              :  data_t'(s5_prod_q[i][NormBits+RcpW-1:UnitBits]);
      end
      s5_neg_q  <= side_q[SideDly-1].neg;
      s5_zero_q <= side_q[SideDly-1].zero;
      zero_q    <= s5_zero_q;
    end
  end

  efp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .sq_i   (s4_sum_q),
    .root_o (root_c)
  );

  efp_recip u_recip (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .root_i (root_c),
    .rcp_o  (rcp_c)
  );

  assign u_o    = u_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

@@ design/efp_project.sv @@
// efp_project: dot product of a unit-scaled vector with three flow values, rounded and saturated
// depends on efp_pkg
`default_nettype none

module efp_project import efp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire wvec_t w_i [3],
  input  wire data_t f_i [3],
  input  wire logic  kill_i,
  output data_t      res_o
);

  localparam logic [DataW:0] MaxPos = {2'b00, {(DataW-1){1'b1}}};
  localparam logic [DataW:0] MaxNeg = {2'b01, {(DataW-1){1'b0}}};

  logic signed [ProdW-1:0] p_q [3];
  logic signed [SumW-1:0]  sum_q;
  logic                    kill1_q, kill2_q;
  data_t                   res_q;

  logic [SumW-1:0]         mag_c, rnd_c;
  logic [SumW-UnitBits-1:0] lo_c;
  logic [DataW:0]          lim_c;
  logic                    neg_c;
  data_t                   res_d;

  always_comb begin
    neg_c = sum_q[SumW-1];
    mag_c = neg_c ? SumW'(-sum_q) : SumW'(sum_q);
    rnd_c = mag_c + (SumW'(1) << (UnitBits - 1));
    lo_c  = rnd_c[SumW-1:UnitBits];
    if (neg_c) begin
      lim_c = (lo_c > (SumW-UnitBits)'(MaxNeg)) ? MaxNeg : lo_c[DataW:0];
    end else begin
      lim_c = (lo_c > (SumW-UnitBits)'(MaxPos)) ? MaxPos : lo_c[DataW:0];
    end
    if (kill2_q) begin
      res_d = '0;
    end else if (neg_c) begin
      res_d = -data_t'(lim_c[DataW-1:0]);
    end else begin
      res_d = data_t'(lim_c[DataW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= w_i[i] * f_i[i];
      end
      kill1_q <= kill_i;
      sum_q   <= SumW'(p_q[0]) + SumW'(p_q[1]) + SumW'(p_q[2]);
      kill2_q <= kill1_q;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ design/edge_frame_flow_projection_core.sv @@
// edge_frame_flow_projection_core: top level, edge tangent and normal frame and flow projections
// depends on efp_pkg, efp_unit_vec, efp_project
//
//  channel   | direction | tdata                                   | tuser
//  s_axis    | in        | end_a xyz, end_b xyz, flow_a xyz, flow_b | -
//  m_axis    | out       | tangent a/b, normal a/b projections      | degenerate
//
//  one transaction accepted per cycle while the pipeline is not held; its depth is set mostly by
//  the square root pipeline (32 stages) and the reciprocal pipeline (32 stages)
//  the whole pipeline advances together: it holds when a result waits and m_axis_tready_i is low
//  rst_ni clears only the valid bits, the datapath registers carry no reset
//  no stored state between transactions
`default_nettype none

module edge_frame_flow_projection_core import efp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
  // flow_a_x, flow_a_y, flow_a_z, flow_b_x, flow_b_y, flow_b_z (32 bits each)
  input  wire logic [NumIn*DataW-1:0] s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // tangent_flow_a, tangent_flow_b, normal_flow_a, normal_flow_b (32 bits each)
  output logic [NumOut*DataW-1:0]     m_axis_tdata_o,
  // degenerate
  output logic [0:0]                  m_axis_tuser_o
);

  logic                      adv;          // whole pipeline moves one step
  logic [TotalLat-1:0]       vld_q;        // valid bit per stage
  logic [NumIn*DataW-1:0]    in_q;         // captured input transaction

  data_t                     end_a [3];
  data_t                     end_b [3];
  data_t                     r_c [3];
  data_t                     t_c [3];
  logic                      r_zero, t_zero;

  // flows wait for the frame; tangent waits for the cross product
  logic [6*DataW-1:0]        flow_dly_q [FlowDly];
  data_t                     t_dly_q [CrossLat][3];
  logic                      kill_q [CrossLat];
  logic                      deg_q [ProjLat];

  logic signed [2*DataW-1:0] pa_q [3];
  logic signed [2*DataW-1:0] pb_q [3];
  wvec_t                     n_q [3];
  logic signed [2*DataW:0]   x_c [3];
  logic [2*DataW:0]          xm_c [3];

  wvec_t                     t_w [3];
  data_t                     flow_a [3];
  data_t                     flow_b [3];
  data_t                     res [NumOut];

  assign adv             = !vld_q[TotalLat-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[TotalLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TotalLat-2:0], s_axis_tvalid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      end_a[i]  = in_q[DataW*i +: DataW];
      end_b[i]  = in_q[DataW*(i+3) +: DataW];
      flow_a[i] = flow_dly_q[FlowDly-1][DataW*i +: DataW];
      flow_b[i] = flow_dly_q[FlowDly-1][DataW*(i+3) +: DataW];
      t_w[i]    = NormVecW'(t_dly_q[CrossLat-1][i]);
      x_c[i]    = (2*DataW+1)'(pa_q[i]) - (2*DataW+1)'(pb_q[i]);
      xm_c[i]   = x_c[i][2*DataW] ? (2*DataW+1)'(-x_c[i]) : (2*DataW+1)'(x_c[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= s_axis_tdata_i;
      flow_dly_q[0] <= in_q[NumIn*DataW-1:6*DataW];
      for (int k = 1; k < FlowDly; k++) begin
        flow_dly_q[k] <= flow_dly_q[k-1];
      end
      // cross product n = r x t, first the products then difference and scaling
      pa_q[0] <= r_c[1] * t_c[2];
      pb_q[0] <= r_c[2] * t_c[1];
      pa_q[1] <= r_c[2] * t_c[0];
      pb_q[1] <= r_c[0] * t_c[2];
      pa_q[2] <= r_c[0] * t_c[1];
      pb_q[2] <= r_c[1] * t_c[0];
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= x_c[i][2*DataW] ? -wvec_t'({1'b0, xm_c[i][UnitBits+NormVecW-2:UnitBits]})
                                  :  wvec_t'({1'b0, xm_c[i][UnitBits+NormVecW-2:UnitBits]});
      end
      t_dly_q[0] <= t_c;
      kill_q[0]  <= r_zero || t_zero;
      for (int k = 1; k < CrossLat; k++) begin
        t_dly_q[k] <= t_dly_q[k-1];
        kill_q[k]  <= kill_q[k-1];
      end
      deg_q[0] <= kill_q[CrossLat-1];
      for (int k = 1; k < ProjLat; k++) begin
        deg_q[k] <= deg_q[k-1];
      end
    end
  end

  // radial direction from the endpoint sum, tangent from the difference
  efp_unit_vec #(.Subtract(1'b0)) u_radial (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (end_a),
    .b_i    (end_b),
    .u_o    (r_c),
    .zero_o (r_zero)
  );

  efp_unit_vec #(.Subtract(1'b1)) u_tangent (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (end_a),
    .b_i    (end_b),
    .u_o    (t_c),
    .zero_o (t_zero)
  );

  efp_project u_proj_ta (
    .clk_i (clk_i), .en_i (adv), .w_i (t_w), .f_i (flow_a),
    .kill_i (kill_q[CrossLat-1]), .res_o (res[0])
  );

  efp_project u_proj_tb (
    .clk_i (clk_i), .en_i (adv), .w_i (t_w), .f_i (flow_b),
    .kill_i (kill_q[CrossLat-1]), .res_o (res[1])
  );

  efp_project u_proj_na (
    .clk_i (clk_i), .en_i (adv), .w_i (n_q), .f_i (flow_a),
    .kill_i (kill_q[CrossLat-1]), .res_o (res[2])
  );

  efp_project u_proj_nb (
    .clk_i (clk_i), .en_i (adv), .w_i (n_q), .f_i (flow_b),
    .kill_i (kill_q[CrossLat-1]), .res_o (res[3])
  );

  assign m_axis_tdata_o = {res[3], res[2], res[1], res[0]};
  assign m_axis_tuser_o = deg_q[ProjLat-1];

  // a degenerate edge carries all-zero projections
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("degenerate result with non-zero projections");

  // while held, no valid bit moves or disappears
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits changed during a stall");

  // an accepted transaction enters the first stage
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule

`default_nettype wire

@@ tb/efp_checker.sv @@
// efp_checker: watches both stream channels, predicts each projection result and compares
// depends on efp_pkg; instantiated beside the block by tb_edge_frame_flow_projection_core
`default_nettype none

module efp_checker import efp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  input  wire logic                   s_axis_tready_i,
  input  wire logic [NumIn*DataW-1:0] s_axis_tdata_i,
  input  wire logic                   m_axis_tvalid_i,
  input  wire logic                   m_axis_tready_i,
  input  wire logic [NumOut*DataW-1:0] m_axis_tdata_i,
  input  wire logic [0:0]             m_axis_tuser_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          seen_degenerate_o,
  output int                          seen_results_o
);

  typedef struct {
    logic [NumOut*DataW-1:0] proj;
    logic                    degen;
  } frame_result_t;

  frame_result_t projections_due[$];

  // unit vector in Q.30 of the endpoint sum or difference; ok is low when the combination is zero
  function automatic void frame_axis(input logic [NumIn*DataW-1:0] item, input bit diff,
                                     output bit ok, output longint unit_out [3]);
    longint    comb [3];
    longint    mag [3];
    longint    v [3];
    logic [63:0] sumsq, root, rcp, m;
    int        len, k;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      comb[i] = diff ? longint'($signed(item[i*DataW +: DataW])) -
                       longint'($signed(item[(3+i)*DataW +: DataW]))
                     : longint'($signed(item[i*DataW +: DataW])) +
                       longint'($signed(item[(3+i)*DataW +: DataW]));
      mag[i] = comb[i] < 0 ? -comb[i] : comb[i];
      for (int b = 0; b < 40; b++) if (mag[i][b]) len = (b + 1 > len) ? b + 1 : len;
    end
    ok = (len != 0);
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > NormBits) begin
        k = len - NormBits;
        v[i] = mag[i] >>> k;
      end else begin
        v[i] = mag[i] << (NormBits - len);
      end
      sumsq += 64'(v[i]) * 64'(v[i]);
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      m = root | (64'd1 << b);
      if (m * m <= sumsq) root = m;
    end
    rcp = ok ? (64'd1 << (2 * UnitBits)) / root : 0;
    for (int i = 0; i < 3; i++) begin
      m = (64'(v[i]) * rcp) >> UnitBits;
      unit_out[i] = comb[i] < 0 ? -longint'(m) : longint'(m);
    end
  endfunction

  function automatic longint cross_trunc(input longint a, b, c, d);
    longint x, r;
    x = a * b - c * d;
    r = (x < 0 ? -x : x) >>> UnitBits;
    return x < 0 ? -r : r;
  endfunction

  // rounded, saturated dot product of a Q.30 vector with three flow fields
  function automatic logic [DataW-1:0] flow_dot(input longint w [3],
                                                input logic [3*DataW-1:0] flow);
    logic signed [127:0] acc, mag, q;
    acc = 0;
    for (int i = 0; i < 3; i++)
      acc += 128'(w[i]) * 128'($signed(flow[i*DataW +: DataW]));
    mag = acc < 0 ? -acc : acc;
    q = (mag + (128'sd1 <<< (UnitBits - 1))) >>> UnitBits;
    if (acc < 0) q = -q;
    if (q > 128'sd2147483647) q = 128'sd2147483647;
    if (q < -128'sd2147483648) q = -128'sd2147483648;
    return q[DataW-1:0];
  endfunction

  function automatic frame_result_t predict_projection(input logic [NumIn*DataW-1:0] item);
    frame_result_t res;
    longint rad [3], tan [3], nrm [3];
    bit     ok_r, ok_t;
    frame_axis(item, 1'b0, ok_r, rad);
    frame_axis(item, 1'b1, ok_t, tan);
    res.proj = '0;
    res.degen = !(ok_r && ok_t);
    if (!res.degen) begin
      nrm[0] = cross_trunc(rad[1], tan[2], rad[2], tan[1]);
      nrm[1] = cross_trunc(rad[2], tan[0], rad[0], tan[2]);
      nrm[2] = cross_trunc(rad[0], tan[1], rad[1], tan[0]);
      res.proj[0*DataW +: DataW] = flow_dot(tan, item[6*DataW +: 3*DataW]);
      res.proj[1*DataW +: DataW] = flow_dot(tan, item[9*DataW +: 3*DataW]);
      res.proj[2*DataW +: DataW] = flow_dot(nrm, item[6*DataW +: 3*DataW]);
      res.proj[3*DataW +: DataW] = flow_dot(nrm, item[9*DataW +: 3*DataW]);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    seen_degenerate_o = 0;
    seen_results_o = 0;
  end

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        projections_due.push_back(predict_projection(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_results_o++;
        if (m_axis_tuser_i[0]) seen_degenerate_o++;
        if (projections_due.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(m_axis_tdata_i[31:0]), 64'd0);
        end else begin
          want = projections_due.pop_front();
          for (int f = 0; f < NumOut; f++)
            if (m_axis_tdata_i[f*DataW +: DataW] !== want.proj[f*DataW +: DataW])
              report_mismatch($sformatf("projection %0d", f),
                              64'(m_axis_tdata_i[f*DataW +: DataW]),
                              64'(want.proj[f*DataW +: DataW]));
          if (m_axis_tuser_i[0] !== want.degen)
            report_mismatch("degenerate", 64'(m_axis_tuser_i[0]), 64'(want.degen));
        end
      end
      pending_o = projections_due.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_edge_frame_flow_projection_core.sv @@
// tb_edge_frame_flow_projection_core: stimulus and verdict for the edge frame projection core
// depends on efp_pkg, edge_frame_flow_projection_core and efp_checker
`default_nettype none

module tb_edge_frame_flow_projection_core import efp_pkg::*; ();

  localparam int RandomItems = 1400;
  localparam int CycleLimit  = 400000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [NumIn*DataW-1:0]  s_axis_tdata_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [NumOut*DataW-1:0] m_axis_tdata_o;
  logic [0:0]              m_axis_tuser_o;
  int fail_count, pending, seen_degen, seen_results;
  int cycle_count = 0;
  bit stall_on = 1'b1;

  always #2 clk_i = ~clk_i;

  edge_frame_flow_projection_core dut (.*);

  efp_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .fail_count_o(fail_count), .pending_o(pending),
    .seen_degenerate_o(seen_degen), .seen_results_o(seen_results)
  );

  // receiver: random stalls, none in a periodic window or while stall_on is low
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (!stall_on) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 9) < 6) || (cycle_count[6:4] == 3'd0);
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) << 24;
      3: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NumIn*DataW-1:0] rand_edge();
    logic [NumIn*DataW-1:0] item;
    for (int i = 0; i < NumIn; i++) item[i*DataW +: DataW] = rand_field();
    case ($urandom_range(0, 9))
      0: item[3*DataW +: 3*DataW] = item[0 +: 3*DataW];          // zero-length difference
      1: for (int i = 0; i < 3; i++)                               // zero-length sum
           item[(3+i)*DataW +: DataW] = -item[i*DataW +: DataW];
      2: begin                                                     // b on the line of a
        item[3*DataW +: DataW] = 0; item[4*DataW +: DataW] = 0; item[5*DataW +: DataW] = 0;
        item[1*DataW +: DataW] = 0; item[2*DataW +: DataW] = 0;
      end
      default: ;
    endcase
    return item;
  endfunction

  // one transaction, held until accepted; gaps are added by the caller
  task automatic send_edge(input logic [NumIn*DataW-1:0] item);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= item;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic idle_cycles(input int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    idle_cycles(1);
    while (pending != 0) @(posedge clk_i);
  endtask

  logic [NumIn*DataW-1:0] edge_item;
  int burst;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, degenerate sum and difference, parallel frame
    edge_item = '0;
    send_edge(edge_item);
    edge_item = {NumIn{32'h7fff_ffff}};
    send_edge(edge_item);
    edge_item = {NumIn{32'h8000_0000}};
    send_edge(edge_item);
    edge_item = {{6{32'h7fff_ffff}}, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0100_0000, 32'h0, 32'h0};
    send_edge(edge_item);
    edge_item = {{6{32'hffff_ffff}}, 32'h0, 32'h0, 32'h0200_0000, 32'h0, 32'h0, 32'h0100_0000};
    send_edge(edge_item);
    edge_item = {{6{32'h7fff_ffff}}, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_edge(edge_item);
    edge_item = {{6{32'h8000_0000}}, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0};
    send_edge(edge_item);
    edge_item = {{6{32'h5555_5555}}, 32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0300_0000};
    send_edge(edge_item);
    for (int d = 0; d < 12; d++) send_edge(rand_edge());

    // hold off until the pipeline has emptied
    drain();

    // random bursts with random gaps; a stretch with no stalls at all
    for (int n = 0; n < RandomItems; ) begin
      if (n > 600 && n < 800) stall_on = 1'b0; else stall_on = 1'b1;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < RandomItems; b++, n++) send_edge(rand_edge());
      idle_cycles($urandom_range(0, 6) == 0 ? $urandom_range(1, 90) : $urandom_range(0, 3));
    end

    drain();
    repeat (TotalLat + 20) @(posedge clk_i);
    $display("covered %0d results, %0d degenerate, with bursty input and output stalls",
             seen_results, seen_degen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
